// File: sv/assert_macros.svh
// Assertion macros shared by the vector unit RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/vprc_pkg.sv
// Package for the vector polar/rectangular unit: mode codes, angle constants.
// Depends on nothing.
package vprc_pkg;
    typedef enum logic [2:0] {
        MODE_RECT = 3'd0, MODE_POLAR = 3'd1, MODE_ADD = 3'd2,
        MODE_SUB = 3'd3, MODE_SCALE = 3'd4, MODE_NEG = 3'd5
    } mode_t;
    localparam int FRACTION_BITS = 16;
    localparam int GUARD_BITS = 8;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic signed [41:0] DEG_PER_RAD_Q32 = 42'sd246083499208;
    localparam logic signed [41:0] ANG_90 = 42'sd386547056640;
    localparam logic signed [41:0] ANG_180 = 42'sd773094113280;
    localparam logic signed [41:0] ANG_360 = 42'sd1546188226560;
    localparam int TABLE_LEN = 16;
    typedef logic signed [41:0] angle_t;
    typedef logic signed [47:0] vec_t;

    function automatic angle_t atan_step(input int i);
        angle_t t [TABLE_LEN];
        t = '{42'sd193273528320, 42'sd114096026022, 42'sd60285206653,
              42'sd30601712202, 42'sd15360239180, 42'sd7687607525,
              42'sd3844741810, 42'sd1922488225, 42'sd961258780,
              42'sd480631223, 42'sd240315841, 42'sd120157949,
              42'sd60078978, 42'sd30039490, 42'sd15019745, 42'sd7509872};
        if (i < TABLE_LEN) return t[i];
        return DEG_PER_RAD_Q32 >>> i;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

// File: sv/vprc_cordic.sv
// CORDIC pipeline: rotation for polar loads then vectoring for every result.
// Depends on vprc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vprc_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic in_rotate,
    input  logic in_bad,
    input  logic signed [31:0] in_a,
    input  logic signed [31:0] in_b,
    output logic out_valid,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic [30:0] out_mag,
    output logic signed [24:0] out_ang,
    output logic out_bad
);
    import vprc_pkg::*;
    localparam int N = CORDIC_STAGES;
    localparam int SH = 32 - FRACTION_BITS;
    // A full turn in input degrees is 45 * 2^TURN_LSB.
    localparam int TURN_LSB = FRACTION_BITS + 3;

    // Rotation chain: stage 0 reduces the angle modulo a full turn and starts the
    // gain pre-scale, stage 1 folds the angle and finishes the gain.
    logic   rv_reg [N+2];
    logic   rr_reg [N+2];
    logic   rb_reg [N+2];
    vec_t   rx_reg [N+2];
    vec_t   ry_reg [N+2];
    angle_t rz_reg [N+2];
    logic signed [31:0] ra_reg [N+2];
    logic signed [31:0] rbv_reg [N+2];
    logic   rd_reg;
    logic   rn_reg;
    logic [63:0] rp_reg;

    // Angle magnitude modulo a full turn: the bits above TURN_LSB are reduced
    // modulo 45 with a reciprocal multiply, the bits below pass unchanged.
    logic [31:0] absd;
    logic [12:0] turn_t;
    logic [27:0] turn_p;
    logic [6:0]  turn_q;
    logic [12:0] turn_r;
    logic [31:0] absm;
    always_comb
    begin
        absd = in_b[31] ? 32'(-in_b) : in_b;
        turn_t = absd[31:TURN_LSB];
        turn_p = 28'(turn_t) * 28'd23302;
        turn_q = turn_p[26:20];
        turn_r = turn_t - 13'(turn_q) * 13'd45;
        absm = in_a[31] ? 32'(-in_a) : in_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rv_reg[0] <= 1'b0;
        else if (en) rv_reg[0] <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg[0] <= in_rotate;
            rb_reg[0] <= in_bad;
            ra_reg[0] <= in_a;
            rbv_reg[0] <= in_b;
            rz_reg[0] <= angle_t'({turn_r[5:0], absd[TURN_LSB-1:0]});
            rd_reg <= in_b[31];
            rn_reg <= in_a[31];
            rp_reg <= 64'(absm) * 64'(GAIN_Q30);
        end
    end

    // Half-turn wrap and quadrant fold of the reduced angle.
    angle_t z_red;
    logic   flip;
    always_comb
    begin
        angle_t z0;
        z0 = (rd_reg ? -rz_reg[0] : rz_reg[0]) <<< SH;
        if (z0 >= ANG_180) z0 = z0 - ANG_360;
        else if (z0 < -ANG_180) z0 = z0 + ANG_360;
        flip = 1'b0;
        if (z0 > ANG_90) begin z0 = z0 - ANG_180; flip = 1'b1; end
        else if (z0 < -ANG_90) begin z0 = z0 + ANG_180; flip = 1'b1; end
        z_red = z0;
    end

    // Stage 1: finish the gain product and apply the sign.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rv_reg[1] <= 1'b0;
        else if (en) rv_reg[1] <= rv_reg[0];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_t g;
            g = vec_t'(rp_reg >> (30 - GUARD_BITS));
            rr_reg[1] <= rr_reg[0];
            rb_reg[1] <= rb_reg[0];
            ra_reg[1] <= ra_reg[0];
            rbv_reg[1] <= rbv_reg[0];
            rz_reg[1] <= z_red;
            rx_reg[1] <= (rn_reg != flip) ? -g : g;
            ry_reg[1] <= '0;
        end
    end
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) rv_reg[i+2] <= 1'b0;
            else if (en) rv_reg[i+2] <= rv_reg[i+1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rr_reg[i+2] <= rr_reg[i+1];
                rb_reg[i+2] <= rb_reg[i+1];
                ra_reg[i+2] <= ra_reg[i+1];
                rbv_reg[i+2] <= rbv_reg[i+1];
                if (rz_reg[i+1] >= 0)
                begin
                    rx_reg[i+2] <= rx_reg[i+1] - (ry_reg[i+1] >>> i);
                    ry_reg[i+2] <= ry_reg[i+1] + (rx_reg[i+1] >>> i);
                    rz_reg[i+2] <= rz_reg[i+1] - atan_step(i);
                end
                else
                begin
                    rx_reg[i+2] <= rx_reg[i+1] + (ry_reg[i+1] >>> i);
                    ry_reg[i+2] <= ry_reg[i+1] - (rx_reg[i+1] >>> i);
                    rz_reg[i+2] <= rz_reg[i+1] + atan_step(i);
                end
            end
        end
    end

    // Result vector selection with guard rounding.
    logic signed [31:0] sel_x, sel_y;
    always_comb
    begin
        vec_t h;
        h = vec_t'(1) <<< (GUARD_BITS - 1);
        if (rr_reg[N+1])
        begin
            sel_x = sat32(66'((rx_reg[N+1] + h) >>> GUARD_BITS));
            sel_y = sat32(66'((ry_reg[N+1] + h) >>> GUARD_BITS));
        end
        else
        begin
            sel_x = ra_reg[N+1];
            sel_y = rbv_reg[N+1];
        end
    end

    // Vectoring chain: stage 0 is the half-plane fold.
    logic   vv_reg [N+1];
    logic   vb_reg [N+1];
    logic   vzero_reg [N+1];
    vec_t   vx_reg [N+1];
    vec_t   vy_reg [N+1];
    angle_t vz_reg [N+1];
    logic signed [31:0] ox_reg [N+1];
    logic signed [31:0] oy_reg [N+1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vv_reg[0] <= 1'b0;
        else if (en) vv_reg[0] <= rv_reg[N+1];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_t x0, y0;
            x0 = vec_t'(sel_x) <<< GUARD_BITS;
            y0 = vec_t'(sel_y) <<< GUARD_BITS;
            vb_reg[0] <= rb_reg[N+1];
            vzero_reg[0] <= (sel_x == 0) && (sel_y == 0);
            ox_reg[0] <= sel_x;
            oy_reg[0] <= sel_y;
            if (sel_x < 0)
            begin
                vx_reg[0] <= -x0;
                vy_reg[0] <= -y0;
                vz_reg[0] <= (sel_y >= 0) ? ANG_180 : -ANG_180;
            end
            else
            begin
                vx_reg[0] <= x0;
                vy_reg[0] <= y0;
                vz_reg[0] <= '0;
            end
        end
    end
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) vv_reg[i+1] <= 1'b0;
            else if (en) vv_reg[i+1] <= vv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vb_reg[i+1] <= vb_reg[i];
                vzero_reg[i+1] <= vzero_reg[i];
                ox_reg[i+1] <= ox_reg[i];
                oy_reg[i+1] <= oy_reg[i];
                if (vy_reg[i] < 0)
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - atan_step(i);
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + atan_step(i);
                end
            end
        end
    end

    // Gain product on the final x, split over two stages.
    logic fv_reg, fb_reg, fz_reg, fneg_reg;
    logic [63:0] fhi_reg, flo_reg;
    logic signed [24:0] fang_reg;
    logic signed [31:0] fx_reg, fy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fv_reg <= 1'b0;
        else if (en) fv_reg <= vv_reg[N];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [47:0] ux;
            angle_t a, lim;
            ux = 48'(vx_reg[N]);
            fneg_reg <= vx_reg[N] < 0;
            fhi_reg <= 64'(ux[47:16]) * 64'(GAIN_Q30);
            flo_reg <= (64'(ux[15:0]) * 64'(GAIN_Q30)) >> 16;
            a = (vz_reg[N] + (angle_t'(1) <<< (SH - 1))) >>> SH;
            lim = angle_t'(180) <<< FRACTION_BITS;
            if (a > lim) a = lim;
            if (a < -lim) a = -lim;
            fang_reg <= a[24:0];
            fb_reg <= vb_reg[N];
            fz_reg <= vzero_reg[N];
            fx_reg <= ox_reg[N];
            fy_reg <= oy_reg[N];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid <= 1'b0;
        else if (en) out_valid <= fv_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [63:0] m;
            m = ((fhi_reg + flo_reg) >> 14) + 64'(1 << (GUARD_BITS - 1));
            m = m >> GUARD_BITS;
            if (m > 64'h7fffffff) m = 64'h7fffffff;
            out_bad <= fb_reg;
            out_x <= fb_reg ? '0 : fx_reg;
            out_y <= fb_reg ? '0 : fy_reg;
            out_mag <= (fb_reg || fz_reg || fneg_reg) ? '0 : m[30:0];
            out_ang <= (fb_reg || fz_reg) ? '0 : fang_reg;
        end
    end

    `ASSERT_IMPL(a_bad_zero, clk, rst_n, out_valid && out_bad,
        out_x == 0 && out_y == 0 && out_mag == 0)
    `ASSERT_NEXT(a_hold, clk, rst_n, !en, $stable(out_valid))
    `ASSERT_IMPL(a_ang_lim, clk, rst_n, out_valid,
        out_ang <= 25'sd11796480 && out_ang >= -25'sd11796480)
endmodule

// File: sv/vector_polar_rect_unit.sv
// Top level of the vector polar/rectangular unit: front-end ops and handshake.
// Depends on vprc_pkg, vprc_cordic and assert_macros.svh.
//
// Channel  | handshake                 | payload
// input    | in_valid / in_ready       | mode, first_x, first_y, second_x, second_y, factor
// output   | out_valid / out_ready     | out_x, out_y, magnitude, angle_deg, bad_mode
//
// One transaction may enter every cycle while in_ready is high; the path runs
// through the front stage, the two unrolled CORDIC chains (rotation then
// vectoring) and the gain products at either end. The whole pipeline advances
// together: when the output holds a result that is not taken, every stage freezes,
// so nothing is lost or repeated. Reset clears only the valid bits.
`include "assert_macros.svh"
module vector_polar_rect_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [2:0] mode,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] factor,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic [30:0] magnitude,
    output logic signed [24:0] angle_deg,
    output logic bad_mode
);
    import vprc_pkg::*;

    // The pipeline moves whenever the output register is free or being taken.
    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // Front stage: the simple operations, with the products registered.
    logic s_v_reg, s_rot_reg, s_bad_reg, s_mul_reg;
    logic signed [31:0] s_a_reg, s_b_reg;
    logic signed [63:0] s_px_reg, s_py_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s_v_reg <= 1'b0;
        else if (en) s_v_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_rot_reg <= mode == MODE_POLAR;
            s_mul_reg <= mode == MODE_SCALE;
            s_px_reg <= first_x * factor;
            s_py_reg <= first_y * factor;
            unique case (mode)
                MODE_RECT, MODE_POLAR, MODE_SCALE:
                begin
                    s_bad_reg <= 1'b0;
                    s_a_reg <= first_x;
                    s_b_reg <= first_y;
                end
                MODE_ADD:
                begin
                    s_bad_reg <= 1'b0;
                    s_a_reg <= sat32(66'(first_x) + 66'(second_x));
                    s_b_reg <= sat32(66'(first_y) + 66'(second_y));
                end
                MODE_SUB:
                begin
                    s_bad_reg <= 1'b0;
                    s_a_reg <= sat32(66'(first_x) - 66'(second_x));
                    s_b_reg <= sat32(66'(first_y) - 66'(second_y));
                end
                MODE_NEG:
                begin
                    s_bad_reg <= 1'b0;
                    s_a_reg <= sat32(-66'(first_x));
                    s_b_reg <= sat32(-66'(first_y));
                end
                default:
                begin
                    s_bad_reg <= 1'b1;
                    s_a_reg <= first_x;
                    s_b_reg <= first_y;
                end
            endcase
        end
    end

    // Rounding of the scale products, halves up.
    logic signed [31:0] a_sel, b_sel;
    always_comb
    begin
        logic signed [65:0] h;
        h = 66'sd1 <<< (FRACTION_BITS - 1);
        if (s_mul_reg)
        begin
            a_sel = sat32((66'(s_px_reg) + h) >>> FRACTION_BITS);
            b_sel = sat32((66'(s_py_reg) + h) >>> FRACTION_BITS);
        end
        else
        begin
            a_sel = s_a_reg;
            b_sel = s_b_reg;
        end
    end

    vprc_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_v_reg),
        .in_rotate(s_rot_reg),
        .in_bad   (s_bad_reg),
        .in_a     (a_sel),
        .in_b     (b_sel),
        .out_valid(out_valid),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_mag  (magnitude),
        .out_ang  (angle_deg),
        .out_bad  (bad_mode)
    );

    `ASSERT_IMPL(a_ready, clk, rst_n, !out_valid, in_ready)
    `ASSERT_NEXT(a_stall, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_x) && $stable(magnitude))
    `ASSERT_IMPL(a_flag, clk, rst_n, out_valid && bad_mode, angle_deg == 0)
endmodule
